@@ hdl/gvpg_pkg.sv @@
// Shared types, constants and helper functions for the grid vignette pattern generator.
// No dependencies; the core module takes everything by scoped name.
package gvpg_pkg;

  // Default texture size.
  localparam int DEF_TEX_WIDTH  = 1024;
  localparam int DEF_TEX_HEIGHT = 1024;

  // Field and datapath widths.
  localparam int COORD_W = 12;          // pixel_x, pixel_y
  localparam int WORD_W  = 32;          // pixel_word
  localparam int CFG_W   = 1;           // bgra_order
  localparam int NUM_W   = 29;          // coord * 2^17 + (size - 1)
  localparam int Q_W     = 17;          // Q1.15 coordinate incl. sign, range [-1, +1]
  localparam int SQ_W    = 31;          // square of a Q1.15 value
  localparam int RAD_W   = 32;          // sum of squares, Q2.30
  localparam int ROOT_W  = 16;          // floor root, Q1.15
  localparam int REM_W   = ROOT_W + 1;  // root remainder
  localparam int FADE_W  = 16;
  localparam int CH_W    = 8;

  // Root pipeline: two result bits per stage.
  localparam int SQRT_STAGES = ROOT_W / 2;

  // Grid line geometry.
  localparam int MAJOR_W     = 7;       // major pitch 128
  localparam int MAJOR_THICK = 3;
  localparam int MINOR_W     = 5;       // minor pitch 32

  // Fade constants, Q1.15.
  localparam logic [FADE_W-1:0] FADE_TOP = 16'd39322;   // 1.2
  localparam logic [FADE_W-1:0] FADE_LOW = 16'd11469;   // 0.35
  localparam logic [FADE_W-1:0] FADE_ONE = 16'd32768;   // 1.0
  localparam logic [ROOT_W-1:0] ROOT_KNEE_LOW  = ROOT_W'(FADE_TOP - FADE_LOW);
  localparam logic [ROOT_W-1:0] ROOT_KNEE_HIGH = ROOT_W'(FADE_TOP - FADE_ONE);
  localparam logic [ROOT_W-1:0] ROOT_MAX = 16'd46340;   // floor(sqrt(2) * 2^15)

  localparam logic [CH_W-1:0] ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    CLS_BASE,
    CLS_MINOR,
    CLS_MAJOR
  } pix_cls_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, top first
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_st_t;

  function automatic rgb_t colour_of(input pix_cls_t cls);
    rgb_t c;
    unique case (cls)
      CLS_MINOR: c = '{r: 8'd56, g: 8'd72,  b: 8'd90};
      CLS_MAJOR: c = '{r: 8'd95, g: 8'd140, b: 8'd175};
      default:   c = '{r: 8'd24, g: 8'd30,  b: 8'd38};
    endcase
    return c;
  endfunction

  // One restoring square-root step: bring down two radicand bits, try a root bit of 1.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t a);
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    sqrt_st_t         b;
    rem2  = {a.rem, a.rad[RAD_W-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    b.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      b.rem  = REM_W'(rem2 - trial);
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = REM_W'(rem2);
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

@@ hdl/grid_vignette_pattern_generator_core.sv @@
// Grid vignette pattern generator: pixel coordinate in, packed RGBA/BGRA word out.
// Depends on gvpg_pkg for widths, fade constants, colour table and the root step.
//
// Usage
//   Input channel:  in_valid / in_stall with pixel_x, pixel_y. A word is taken at a
//                   rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with pixel_word. A word leaves at a rising
//                   edge with out_valid high and out_stall low.
//   Config channel: cfg_valid / cfg_ready with bgra_order; cfg_ready is always high.
//                   Write it only while no word is in flight.
// Timing
//   Fourteen register stages: coordinate divide by reciprocal multiply, rounding
//   correction, squares, sum, eight root stages (two bits each), fade clamp, and the
//   channel scale and pack into the output register. One word per cycle is sustained
//   while out_stall stays low.
// Stall
//   Each stage advances when it is empty or the stage after it advances, so bubbles
//   collapse and words keep entering while the output waits; in_stall rises only when
//   every stage holds a word and out_stall is high. Nothing is dropped or repeated.
// Reset
//   rst (synchronous) clears all stage valid bits and sets bgra_order to 0 (RGBA).
module grid_vignette_pattern_generator_core #(
  parameter int TEX_WIDTH  = gvpg_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = gvpg_pkg::DEF_TEX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gvpg_pkg::COORD_W-1:0] pixel_x,
  input  logic [gvpg_pkg::COORD_W-1:0] pixel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gvpg_pkg::WORD_W-1:0]  pixel_word,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gvpg_pkg::CFG_W-1:0]   bgra_order
);

  localparam int NUM_W = gvpg_pkg::NUM_W;
  localparam int Q_W   = gvpg_pkg::Q_W;
  localparam int PROD_W = 2 * NUM_W;
  localparam int CHK_W  = NUM_W + 2;

  // Round(2^16 * c / (size - 1)) = floor(N / D) with N = c * 2^17 + (size - 1),
  // D = 2 * (size - 1). Quotient estimated as N * floor(2^29 / D) >> 29, then one
  // compare fixes the estimate, which is never more than one low.
  localparam logic [NUM_W-1:0] OFS_X = NUM_W'(TEX_WIDTH - 1);
  localparam logic [NUM_W-1:0] OFS_Y = NUM_W'(TEX_HEIGHT - 1);
  localparam logic [NUM_W-1:0] DEN_X = NUM_W'(2 * (TEX_WIDTH - 1));
  localparam logic [NUM_W-1:0] DEN_Y = NUM_W'(2 * (TEX_HEIGHT - 1));
  localparam logic [NUM_W-1:0] RCP_X = NUM_W'((1 << NUM_W) / (2 * (TEX_WIDTH - 1)));
  localparam logic [NUM_W-1:0] RCP_Y = NUM_W'((1 << NUM_W) / (2 * (TEX_HEIGHT - 1)));
  localparam logic [gvpg_pkg::COORD_W:0] LAST_X = (gvpg_pkg::COORD_W + 1)'(TEX_WIDTH - 1);
  localparam logic [gvpg_pkg::COORD_W:0] LAST_Y = (gvpg_pkg::COORD_W + 1)'(TEX_HEIGHT - 1);
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(32768);

  // Stage positions.
  localparam int ST_MUL   = 0;
  localparam int ST_UV    = 1;
  localparam int ST_SQ    = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_ROOT0 = 4;
  localparam int ST_FADE  = ST_ROOT0 + gvpg_pkg::SQRT_STAGES;
  localparam int ST_OUT   = ST_FADE + 1;
  localparam int N_ST     = ST_OUT + 1;

  // ---------------------------------------------------------------- flow control
  logic [N_ST-1:0] vld;
  logic [N_ST-1:0] vld_in;
  logic [N_ST-1:0] en;

  assign vld_in = {vld[N_ST-2:0], in_valid};

  // A stage may load when empty or when its contents move on.
  always_comb begin
    en[N_ST-1] = !vld[N_ST-1] || !out_stall;
    for (int k = N_ST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N_ST; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign in_stall  = !en[ST_MUL];
  assign out_valid = vld[ST_OUT];

  // ---------------------------------------------------------------- config
  logic bgra_sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bgra_sel <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bgra_sel <= bgra_order[0];
    end
  end

  // ---------------------------------------------------------------- stage 0
  // Classify the pixel and start the coordinate scaling.
  logic [NUM_W-1:0]  num_x, num_y;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic              is_major, is_minor;
  gvpg_pkg::pix_cls_t cls_in;

  logic [gvpg_pkg::COORD_W-1:0] s0_x, s0_y;
  logic [Q_W-1:0]               s0_qx, s0_qy;
  logic                         s0_satx, s0_saty;
  gvpg_pkg::pix_cls_t           s0_cls;

  assign num_x  = {pixel_x, 17'd0} + OFS_X;
  assign num_y  = {pixel_y, 17'd0} + OFS_Y;
  assign prod_x = PROD_W'(num_x) * PROD_W'(RCP_X);
  assign prod_y = PROD_W'(num_y) * PROD_W'(RCP_Y);

  assign is_major = (pixel_x[gvpg_pkg::MAJOR_W-1:0] < gvpg_pkg::MAJOR_W'(gvpg_pkg::MAJOR_THICK))
                 || (pixel_y[gvpg_pkg::MAJOR_W-1:0] < gvpg_pkg::MAJOR_W'(gvpg_pkg::MAJOR_THICK));
  assign is_minor = (pixel_x[gvpg_pkg::MINOR_W-1:0] == '0)
                 || (pixel_y[gvpg_pkg::MINOR_W-1:0] == '0);

  // Major wins over minor, minor over base.
  always_comb begin
    if (is_major)      cls_in = gvpg_pkg::CLS_MAJOR;
    else if (is_minor) cls_in = gvpg_pkg::CLS_MINOR;
    else               cls_in = gvpg_pkg::CLS_BASE;
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      s0_x    <= pixel_x;
      s0_y    <= pixel_y;
      s0_qx   <= prod_x[NUM_W +: Q_W];
      s0_qy   <= prod_y[NUM_W +: Q_W];
      s0_satx <= {1'b0, pixel_x} >= LAST_X;   // at or past the last column: +1.0
      s0_saty <= {1'b0, pixel_y} >= LAST_Y;
      s0_cls  <= cls_in;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Fix the quotient estimate and center it to Q1.15.
  logic [CHK_W-1:0] n1_x, n1_y, chk_x, chk_y;
  logic [Q_W-1:0]   q_x, q_y;

  logic signed [Q_W-1:0] s1_u, s1_v;
  gvpg_pkg::pix_cls_t    s1_cls;

  assign n1_x  = CHK_W'({s0_x, 17'd0}) + CHK_W'(OFS_X);
  assign n1_y  = CHK_W'({s0_y, 17'd0}) + CHK_W'(OFS_Y);
  assign chk_x = CHK_W'(s0_qx) * CHK_W'(DEN_X) + CHK_W'(DEN_X);
  assign chk_y = CHK_W'(s0_qy) * CHK_W'(DEN_Y) + CHK_W'(DEN_Y);
  assign q_x   = s0_qx + Q_W'(n1_x >= chk_x);
  assign q_y   = s0_qy + Q_W'(n1_y >= chk_y);

  always_ff @(posedge clk) begin
    if (en[ST_UV]) begin
      s1_u   <= s0_satx ? Q_ONE : signed'(q_x - Q_ONE);
      s1_v   <= s0_saty ? Q_ONE : signed'(q_y - Q_ONE);
      s1_cls <= s0_cls;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [2*Q_W-1:0]      uu, vv;
  logic [gvpg_pkg::SQ_W-1:0]    s2_uu, s2_vv;
  gvpg_pkg::pix_cls_t           s2_cls;

  assign uu = s1_u * s1_u;
  assign vv = s1_v * s1_v;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      s2_uu  <= uu[gvpg_pkg::SQ_W-1:0];
      s2_vv  <= vv[gvpg_pkg::SQ_W-1:0];
      s2_cls <= s1_cls;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [gvpg_pkg::RAD_W-1:0] s3_rad;
  gvpg_pkg::pix_cls_t         s3_cls;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      s3_rad <= gvpg_pkg::RAD_W'(s2_uu) + gvpg_pkg::RAD_W'(s2_vv);
      s3_cls <= s2_cls;
    end
  end

  // ---------------------------------------------------------------- root stages
  gvpg_pkg::sqrt_st_t sq     [gvpg_pkg::SQRT_STAGES];
  gvpg_pkg::pix_cls_t sq_cls [gvpg_pkg::SQRT_STAGES];

  for (genvar g = 0; g < gvpg_pkg::SQRT_STAGES; g++) begin : g_root
    gvpg_pkg::sqrt_st_t st_in;
    gvpg_pkg::pix_cls_t cls_src;

    if (g == 0) begin : g_first
      assign st_in   = '{rad: s3_rad, root: '0, rem: '0};
      assign cls_src = s3_cls;
    end else begin : g_rest
      assign st_in   = sq[g-1];
      assign cls_src = sq_cls[g-1];
    end

    always_ff @(posedge clk) begin
      if (en[ST_ROOT0 + g]) begin
        sq[g]     <= gvpg_pkg::sqrt_step(gvpg_pkg::sqrt_step(st_in));
        sq_cls[g] <= cls_src;
      end
    end
  end

  // ---------------------------------------------------------------- fade stage
  logic [gvpg_pkg::ROOT_W-1:0] root;
  logic [gvpg_pkg::FADE_W-1:0] fade_next;
  logic [gvpg_pkg::FADE_W-1:0] fade;
  gvpg_pkg::pix_cls_t          fd_cls;

  assign root = sq[gvpg_pkg::SQRT_STAGES-1].root;

  // Clamp 1.2 - r to [0.35, 1.0].
  always_comb begin
    if (root >= gvpg_pkg::ROOT_KNEE_LOW)       fade_next = gvpg_pkg::FADE_LOW;
    else if (root <= gvpg_pkg::ROOT_KNEE_HIGH) fade_next = gvpg_pkg::FADE_ONE;
    else                                       fade_next = gvpg_pkg::FADE_TOP - root;
  end

  always_ff @(posedge clk) begin
    if (en[ST_FADE]) begin
      fade   <= fade_next;
      fd_cls <= sq_cls[gvpg_pkg::SQRT_STAGES-1];
    end
  end

  // ---------------------------------------------------------------- output stage
  localparam int SCL_W = gvpg_pkg::CH_W + gvpg_pkg::FADE_W;

  gvpg_pkg::rgb_t              colour;
  logic [SCL_W-1:0]            scl_r, scl_g, scl_b;
  logic [gvpg_pkg::CH_W-1:0]   ch_r, ch_g, ch_b;
  logic [gvpg_pkg::WORD_W-1:0] word_next;

  assign colour = gvpg_pkg::colour_of(fd_cls);
  assign scl_r  = SCL_W'(colour.r) * SCL_W'(fade);
  assign scl_g  = SCL_W'(colour.g) * SCL_W'(fade);
  assign scl_b  = SCL_W'(colour.b) * SCL_W'(fade);
  assign ch_r   = scl_r[15 +: gvpg_pkg::CH_W];
  assign ch_g   = scl_g[15 +: gvpg_pkg::CH_W];
  assign ch_b   = scl_b[15 +: gvpg_pkg::CH_W];

  // Alpha on top; red or blue in the low byte as configured.
  assign word_next = bgra_sel ? {gvpg_pkg::ALPHA, ch_r, ch_g, ch_b}
                              : {gvpg_pkg::ALPHA, ch_b, ch_g, ch_r};

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      pixel_word <= word_next;
    end
  end

  // ---------------------------------------------------------------- checks
  // Input backs up only when every stage holds a word and the output waits.
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld == {N_ST{1'b1}}) && out_stall)
    else $error("input stalled with room in the pipeline");

  a_uv_range : assert property (@(posedge clk) disable iff (rst)
    vld[ST_UV] |-> (s1_u >= -17'sd32768) && (s1_u <= 17'sd32768)
                && (s1_v >= -17'sd32768) && (s1_v <= 17'sd32768))
    else $error("centered coordinate outside [-1, +1]");

  a_root_range : assert property (@(posedge clk) disable iff (rst)
    vld[ST_FADE-1] |-> root <= gvpg_pkg::ROOT_MAX)
    else $error("root beyond sqrt(2)");

  a_fade_range : assert property (@(posedge clk) disable iff (rst)
    vld[ST_OUT-1] |-> (fade >= gvpg_pkg::FADE_LOW) && (fade <= gvpg_pkg::FADE_ONE))
    else $error("fade outside its clamp");

endmodule

@@ sim/gvpg_pixel_check.sv @@
// Pixel word checker for the grid vignette pattern generator: watches the config,
// input and output channels, predicts each packed colour and compares it in order.
// Depends on gvpg_pkg for field widths, fade constants and the pixel class enum.
`timescale 1ns / 1ps

module gvpg_pixel_check #(
  parameter int TEX_WIDTH  = gvpg_pkg::DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT = gvpg_pkg::DEF_TEX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [gvpg_pkg::COORD_W-1:0] pixel_x,
  input  logic [gvpg_pkg::COORD_W-1:0] pixel_y,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [gvpg_pkg::WORD_W-1:0]  pixel_word,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [gvpg_pkg::CFG_W-1:0]   bgra_order,
  output int                           fail_count,
  output int                           words_pending,
  output int                           words_checked,
  output int                           bgra_words
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [gvpg_pkg::COORD_W-1:0] x;
    logic [gvpg_pkg::COORD_W-1:0] y;
    logic                         bgra;
    logic [gvpg_pkg::WORD_W-1:0]  word;
  } pixel_expect_t;

  pixel_expect_t              colour_queue[$];
  logic [gvpg_pkg::CFG_W-1:0] order_shadow;
  int                         reported;

  // Map a coordinate onto [-1, +1] in Q1.15, rounded half up, saturated at +1.
  function automatic longint coord_q15(input longint c, input longint size);
    longint d;
    longint q;
    d = (size > 1) ? size - 1 : 1;
    q = (2 * c * 65536 + d) / (2 * d);
    if (q > 65536) q = 65536;
    return q - 32768;
  endfunction

  function automatic logic [gvpg_pkg::WORD_W-1:0] shade_pixel(
    input logic [gvpg_pkg::COORD_W-1:0] x,
    input logic [gvpg_pkg::COORD_W-1:0] y,
    input logic                         bgra
  );
    longint             u;
    longint             v;
    longint             radius_sq;
    longint             root;
    longint             trial;
    longint             fade;
    gvpg_pkg::pix_cls_t cls;
    longint             cr;
    longint             cg;
    longint             cb;
    logic [7:0]         r8;
    logic [7:0]         g8;
    logic [7:0]         b8;
    u = coord_q15(longint'(x), TEX_WIDTH);
    v = coord_q15(longint'(y), TEX_HEIGHT);
    radius_sq = u * u + v * v;
    // Floor root by setting result bits from the top down.
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radius_sq) root = trial;
    end
    fade = longint'(gvpg_pkg::FADE_TOP) - root;
    if (fade < longint'(gvpg_pkg::FADE_LOW)) fade = longint'(gvpg_pkg::FADE_LOW);
    if (fade > longint'(gvpg_pkg::FADE_ONE)) fade = longint'(gvpg_pkg::FADE_ONE);
    // Major lines win over minor lines, minor over the base.
    cls = gvpg_pkg::CLS_BASE;
    if (x[4:0] == 5'd0 || y[4:0] == 5'd0) cls = gvpg_pkg::CLS_MINOR;
    if (x[6:0] < 7'd3 || y[6:0] < 7'd3) cls = gvpg_pkg::CLS_MAJOR;
    case (cls)
      gvpg_pkg::CLS_MAJOR: begin
        cr = 95; cg = 140; cb = 175;
      end
      gvpg_pkg::CLS_MINOR: begin
        cr = 56; cg = 72; cb = 90;
      end
      default: begin
        cr = 24; cg = 30; cb = 38;
      end
    endcase
    r8 = 8'((cr * fade) >> 15);
    g8 = 8'((cg * fade) >> 15);
    b8 = 8'((cb * fade) >> 15);
    if (bgra) return {gvpg_pkg::ALPHA, r8, g8, b8};
    return {gvpg_pkg::ALPHA, b8, g8, r8};
  endfunction

  always @(posedge clk) begin : watch
    pixel_expect_t head;
    pixel_expect_t fresh;
    if (rst) begin
      colour_queue.delete();
      order_shadow = '0;
      fail_count = 0;
      words_checked = 0;
      bgra_words = 0;
      reported = 0;
    end else begin
      if (cfg_valid && cfg_ready) order_shadow = bgra_order;
      if (in_valid && !in_stall) begin
        fresh.x    = pixel_x;
        fresh.y    = pixel_y;
        fresh.bgra = order_shadow[0];
        fresh.word = shade_pixel(pixel_x, pixel_y, order_shadow[0]);
        colour_queue.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        if (colour_queue.size() == 0) begin
          fail_count++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("[%0t] unexpected pixel word %h", $time, pixel_word);
          end
        end else begin
          head = colour_queue.pop_front();
          words_checked++;
          if (head.bgra) bgra_words++;
          if (pixel_word !== head.word) begin
            fail_count++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("[%0t] pixel (%0d,%0d) bgra=%0d: expected %h, got %h", $time,
                       head.x, head.y, head.bgra, head.word, pixel_word);
            end
          end
        end
      end
    end
    words_pending = colour_queue.size();
  end

endmodule

@@ sim/grid_vignette_pattern_generator_core_test.sv @@
// Testbench top for the grid vignette pattern generator core: drives pixel coordinates,
// random output stalls and channel order writes; the verdict comes from gvpg_pixel_check.
// Depends on gvpg_pkg, grid_vignette_pattern_generator_core and gvpg_pixel_check.
`timescale 1ns / 1ps

module grid_vignette_pattern_generator_core_test;

  localparam int TEX_W        = gvpg_pkg::DEF_TEX_WIDTH;
  localparam int TEX_H        = gvpg_pkg::DEF_TEX_HEIGHT;
  localparam int DRAIN_CYCLES = 20;      // pipeline is 14 stages deep
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 100;
  localparam int DIR_N        = 24;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [gvpg_pkg::COORD_W-1:0] pixel_x = '0;
  logic [gvpg_pkg::COORD_W-1:0] pixel_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [gvpg_pkg::WORD_W-1:0]  pixel_word;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [gvpg_pkg::CFG_W-1:0]   bgra_order = '0;

  int  fail_count;
  int  words_pending;
  int  words_checked;
  int  bgra_words;
  int  order_writes;

  // Phase knobs: when set, that side runs without gaps.
  bit  calm_in;
  bit  calm_out;

  // Directed coordinates: corners (fade clamped low), center (fade clamped high),
  // beyond-texture saturation, both sides of the major and minor line edges, and
  // alternating bit patterns.
  logic [gvpg_pkg::COORD_W-1:0] dir_x [DIR_N] = '{
    12'd0,    12'd1023, 12'd511,  12'd512,  12'd4095, 12'd1024, 12'd300,  12'd1,
    12'd2,    12'd3,    12'd32,   12'd700,  12'd130,  12'd131,  12'd160,  12'd0,
    12'd1023, 12'd4095, 12'd0,    12'd2730, 12'd1365, 12'd256,  12'd767,  12'd900
  };
  logic [gvpg_pkg::COORD_W-1:0] dir_y [DIR_N] = '{
    12'd0,    12'd1023, 12'd511,  12'd512,  12'd4095, 12'd300,  12'd1024, 12'd700,
    12'd700,  12'd700,  12'd700,  12'd64,   12'd450,  12'd450,  12'd480,  12'd1023,
    12'd0,    12'd0,    12'd4095, 12'd1365, 12'd2730, 12'd511,  12'd255,  12'd100
  };

  grid_vignette_pattern_generator_core #(
    .TEX_WIDTH (TEX_W),
    .TEX_HEIGHT(TEX_H)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_word(pixel_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .bgra_order(bgra_order)
  );

  gvpg_pixel_check #(
    .TEX_WIDTH (TEX_W),
    .TEX_HEIGHT(TEX_H)
  ) pixel_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_word   (pixel_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .bgra_order   (bgra_order),
    .fail_count   (fail_count),
    .words_pending(words_pending),
    .words_checked(words_checked),
    .bgra_words   (bgra_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~550 words, each with long gaps
  // and long stalls on both sides).
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Coordinate: mostly inside the texture, some hugging grid line edges,
  // some anywhere in the 12-bit range (beyond the texture included).
  function automatic logic [gvpg_pkg::COORD_W-1:0] pick_coord(input int size);
    int roll;
    int pitch;
    int c;
    roll = $urandom_range(0, 9);
    if (roll < 6) return gvpg_pkg::COORD_W'($urandom_range(0, size - 1));
    if (roll < 8) begin
      pitch = ($urandom_range(0, 1) == 0) ? 128 : 32;
      c = int'($urandom_range(0, (size - 1) / pitch)) * pitch
          + int'($urandom_range(0, 4)) - 2;
      if (c < 0) c = 0;
      return gvpg_pkg::COORD_W'(c);
    end
    return gvpg_pkg::COORD_W'($urandom_range(0, 4095));
  endfunction

  // Output side: hold stall for a random stretch, then release for a while.
  initial begin : stall_gen
    int hold;
    int run;
    forever begin
      hold = calm_out ? 0 : pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Offer one coordinate word and hold it until the core takes it.
  // Stall is sampled at the falling edge, where every input is settled.
  task automatic send_pixel(input logic [gvpg_pkg::COORD_W-1:0] x,
                            input logic [gvpg_pkg::COORD_W-1:0] y);
    int gap;
    bit took;
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the channel order register; only called while the core is idle.
  task automatic write_order(input logic [gvpg_pkg::CFG_W-1:0] value);
    bit got;
    cfg_valid  <= 1'b1;
    bgra_order <= value;
    do begin
      @(negedge clk);
      got = cfg_ready;
      @(posedge clk);
    end while (!got);
    cfg_valid <= 1'b0;
    order_writes++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [gvpg_pkg::CFG_W-1:0] order;
    calm_in      = 1'b0;
    calm_out     = 1'b0;
    order_writes = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass in both channel orders.
    for (int pass = 0; pass < 2; pass++) begin
      write_order(gvpg_pkg::CFG_W'(pass));
      for (int i = 0; i < DIR_N; i++) send_pixel(dir_x[i], dir_y[i]);
      settle();
    end

    // Random phases: first one back to back on both sides, the rest mixed.
    for (int ph = 0; ph < PHASES; ph++) begin
      calm_in  = (ph == 0) || ($urandom_range(0, 3) == 0);
      calm_out = (ph == 0) || ($urandom_range(0, 3) == 0);
      order    = (ph == PHASES - 1) ? gvpg_pkg::CFG_W'(0)
                                    : gvpg_pkg::CFG_W'($urandom_range(0, 1));
      if (ph == 1) order = gvpg_pkg::CFG_W'(1);
      write_order(order);
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(pick_coord(TEX_W), pick_coord(TEX_H));
      settle();
    end

    $display("Checked %0d pixel words (%0d packed blue first) over %0d order writes,",
             words_checked, bgra_words, order_writes);
    $display("including clamped fades, line edges and beyond-texture coordinates.");
    if (fail_count == 0 && words_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gvpg_pkg.sv
hdl/grid_vignette_pattern_generator_core.sv
sim/gvpg_pixel_check.sv
sim/grid_vignette_pattern_generator_core_test.sv
